// ===== rtl/core/dctl_pkg.sv =====
`default_nettype none
package dctl_pkg;

    localparam int DRIVE_SLOTS  = 4;
    localparam int SECTOR_BYTES = 512;
    localparam int SLOT_W       = 41;
    localparam int CFG_IDX_W    = 4;
    localparam int MAX_XFER     = 63;
    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);

    localparam logic [15:0] SECTOR_STEP = 16'(SECTOR_BYTES);

    typedef enum logic [1:0] {
        ACT_RESET  = 2'd0,
        ACT_READ   = 2'd1,
        ACT_WRITE  = 2'd2,
        ACT_PARAMS = 2'd3
    } action_t;

    // One classified request, as handed from front to back.
    typedef struct packed {
        logic        is_status;
        logic        carry;
        logic        is_write;
        logic [31:0] lba;
        logic [19:0] seg_base;
        logic [15:0] offset;
        logic [5:0]  count;
        logic [1:0]  drive_count;
        logic [7:0]  pcl;
        logic [7:0]  psc;
        logic [7:0]  pmh;
    } req_t;

    function automatic logic slot_present(input logic [SLOT_W-1:0] s);
        return s[0];
    endfunction

    function automatic logic [7:0] slot_drive(input logic [SLOT_W-1:0] s);
        return s[8:1];
    endfunction

    function automatic logic [15:0] slot_cyls(input logic [SLOT_W-1:0] s);
        return s[24:9];
    endfunction

    function automatic logic [7:0] slot_heads(input logic [SLOT_W-1:0] s);
        return s[32:25];
    endfunction

    function automatic logic [7:0] slot_spt(input logic [SLOT_W-1:0] s);
        return s[40:33];
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/disk_chs_to_lba_service.sv =====
// Path: a two-stage classify pipeline, a 4-entry queue, then an output register.
// Throughput: one result beat per cycle while m_ready is high; a transfer holds
//   the sector sequencer until its last sector, any other request for one beat.
//   Requests enter back to back unless the queue and pipeline are stalled.
// Reset: synchronous, active low; clears drive slots (all absent), pipeline, queue
//   and output valid. No clearing pass.
`default_nettype none
module disk_chs_to_lba_service (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [dctl_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [dctl_pkg::SLOT_W-1:0]    cfg_data,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic [1:0]                     s_action,
    input  wire logic [7:0]                     s_drive_number,
    input  wire logic [7:0]                     s_cyl_low,
    input  wire logic [7:0]                     s_sector_and_cyl_high,
    input  wire logic [7:0]                     s_head_number,
    input  wire logic [7:0]                     s_sector_count,
    input  wire logic [15:0]                    s_buffer_segment,
    input  wire logic [15:0]                    s_buffer_offset,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic                                m_kind,
    output logic [31:0]                         m_sector_lba,
    output logic [19:0]                         m_memory_address,
    output logic                                m_is_write,
    output logic                                m_last,
    output logic                                m_carry,
    output logic [1:0]                          m_drive_count,
    output logic [7:0]                          m_param_cyl_low,
    output logic [7:0]                          m_param_sector_cyl_high,
    output logic [7:0]                          m_param_max_head
);

    logic           q_push, q_full, q_pop, q_nonempty;
    dctl_pkg::req_t q_in, q_head;

    dctl_front u_front (
        .aclk                  (aclk),
        .aresetn               (aresetn),
        .cfg_valid             (cfg_valid),
        .cfg_ready             (cfg_ready),
        .cfg_index             (cfg_index),
        .cfg_data              (cfg_data),
        .s_valid               (s_valid),
        .s_ready               (s_ready),
        .s_action              (s_action),
        .s_drive_number        (s_drive_number),
        .s_cyl_low             (s_cyl_low),
        .s_sector_and_cyl_high (s_sector_and_cyl_high),
        .s_head_number         (s_head_number),
        .s_sector_count        (s_sector_count),
        .s_buffer_segment      (s_buffer_segment),
        .s_buffer_offset       (s_buffer_offset),
        .q_push                (q_push),
        .q_data                (q_in),
        .q_full                (q_full)
    );

    dctl_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .head      (q_head),
        .nonempty  (q_nonempty)
    );

    dctl_back u_back (
        .aclk                    (aclk),
        .aresetn                 (aresetn),
        .q_head                  (q_head),
        .q_nonempty              (q_nonempty),
        .q_pop                   (q_pop),
        .m_valid                 (m_valid),
        .m_ready                 (m_ready),
        .m_kind                  (m_kind),
        .m_sector_lba            (m_sector_lba),
        .m_memory_address        (m_memory_address),
        .m_is_write              (m_is_write),
        .m_last                  (m_last),
        .m_carry                 (m_carry),
        .m_drive_count           (m_drive_count),
        .m_param_cyl_low         (m_param_cyl_low),
        .m_param_sector_cyl_high (m_param_sector_cyl_high),
        .m_param_max_head        (m_param_max_head)
    );

endmodule
`default_nettype wire

// ===== rtl/core/dctl_front.sv =====
`default_nettype none
module dctl_front (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [dctl_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [dctl_pkg::SLOT_W-1:0]   cfg_data,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [1:0]                    s_action,
    input  wire logic [7:0]                    s_drive_number,
    input  wire logic [7:0]                    s_cyl_low,
    input  wire logic [7:0]                    s_sector_and_cyl_high,
    input  wire logic [7:0]                    s_head_number,
    input  wire logic [7:0]                    s_sector_count,
    input  wire logic [15:0]                   s_buffer_segment,
    input  wire logic [15:0]                   s_buffer_offset,
    output logic                               q_push,
    output dctl_pkg::req_t                     q_data,
    input  wire logic                          q_full
);

    logic [dctl_pkg::SLOT_W-1:0] slot_reg [dctl_pkg::DRIVE_SLOTS];

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        for (int i = 0; i < dctl_pkg::DRIVE_SLOTS; i++) begin
            if (!aresetn) begin
                slot_reg[i] <= '0;
            end else if (cfg_valid && cfg_index == dctl_pkg::CFG_IDX_W'(i)) begin
                slot_reg[i] <= cfg_data;
            end
        end
    end

    // drive lookup: lowest present slot wins
    logic                        hit, nxt_hit;
    logic [dctl_pkg::SLOT_W-1:0] hit_slot;
    logic [7:0]                  nxt_drive;

    assign nxt_drive = s_drive_number + 8'd1;

    always_comb begin
        hit      = 1'b0;
        nxt_hit  = 1'b0;
        hit_slot = '0;
        for (int i = dctl_pkg::DRIVE_SLOTS - 1; i >= 0; i--) begin
            if (dctl_pkg::slot_present(slot_reg[i]) &&
                dctl_pkg::slot_drive(slot_reg[i]) == s_drive_number) begin
                hit      = 1'b1;
                hit_slot = slot_reg[i];
            end
            if (dctl_pkg::slot_present(slot_reg[i]) &&
                dctl_pkg::slot_drive(slot_reg[i]) == nxt_drive) begin
                nxt_hit = 1'b1;
            end
        end
    end

    // stage 1: registered request plus selected geometry
    logic                        s1_valid_reg, s1_valid_next;
    logic [1:0]                  s1_action_reg;
    logic                        s1_hit_reg, s1_nxt_reg;
    logic [dctl_pkg::SLOT_W-1:0] s1_slot_reg;
    logic [9:0]                  s1_cyl_reg;
    logic [5:0]                  s1_sec_reg;
    logic [7:0]                  s1_head_reg, s1_cnt_reg;
    logic [15:0]                 s1_seg_reg, s1_off_reg;

    // stage 2: classified, with the first partial product
    logic                        s2_valid_reg, s2_valid_next;
    dctl_pkg::req_t              s2_req_reg, s2_req_next;
    logic [18:0]                 s2_part_reg, s2_part_next;
    logic [7:0]                  s2_spt_reg;
    logic [5:0]                  s2_sec_reg;

    logic s1_adv, s2_adv;

    assign q_push  = s2_valid_reg && !q_full;
    assign s2_adv  = !s2_valid_reg || q_push;
    assign s1_adv  = s1_valid_reg && s2_adv;
    assign s_ready = !s1_valid_reg || s2_adv;

    assign s1_valid_next = s_ready ? s_valid : s1_valid_reg;
    assign s2_valid_next = s2_adv ? s1_valid_reg : s2_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            s1_action_reg <= s_action;
            s1_hit_reg    <= hit;
            s1_nxt_reg    <= nxt_hit;
            s1_slot_reg   <= hit_slot;
            s1_cyl_reg    <= {s_sector_and_cyl_high[7:6], s_cyl_low};
            s1_sec_reg    <= s_sector_and_cyl_high[5:0];
            s1_head_reg   <= s_head_number;
            s1_cnt_reg    <= s_sector_count;
            s1_seg_reg    <= s_buffer_segment;
            s1_off_reg    <= s_buffer_offset;
        end
        if (s1_adv) begin
            s2_req_reg  <= s2_req_next;
            s2_part_reg <= s2_part_next;
            s2_spt_reg  <= dctl_pkg::slot_spt(s1_slot_reg);
            s2_sec_reg  <= s1_sec_reg;
        end
    end

    logic [15:0] ncyl, maxcyl;
    logic [7:0]  nhead, spt;
    logic [8:0]  sec_end;
    logic        bad_geom;

    always_comb begin
        ncyl    = dctl_pkg::slot_cyls(s1_slot_reg);
        nhead   = dctl_pkg::slot_heads(s1_slot_reg);
        spt     = dctl_pkg::slot_spt(s1_slot_reg);
        maxcyl  = ncyl - 16'd1;
        sec_end = {3'b0, s1_sec_reg} + {1'b0, s1_cnt_reg};
        bad_geom = ({6'b0, s1_cyl_reg} >= ncyl) || (s1_head_reg >= nhead) ||
                   (s1_sec_reg == 6'd0) || ({2'b0, s1_sec_reg} > spt) ||
                   (sec_end > {1'b0, spt} + 9'd1) ||
                   (s1_cnt_reg > 8'(dctl_pkg::MAX_XFER));

        s2_part_next = {9'b0, s1_cyl_reg} * {11'b0, nhead} + {11'b0, s1_head_reg};

        s2_req_next             = '0;
        s2_req_next.is_status   = 1'b1;
        s2_req_next.is_write    = (dctl_pkg::action_t'(s1_action_reg) == dctl_pkg::ACT_WRITE);
        s2_req_next.seg_base    = {s1_seg_reg, 4'b0};
        s2_req_next.offset      = s1_off_reg;
        s2_req_next.count       = s1_cnt_reg[5:0];

        priority if (dctl_pkg::action_t'(s1_action_reg) == dctl_pkg::ACT_RESET) begin
            s2_req_next.carry = 1'b0;
        end else if (!s1_hit_reg) begin
            s2_req_next.carry = 1'b1;
        end else if (dctl_pkg::action_t'(s1_action_reg) == dctl_pkg::ACT_PARAMS) begin
            s2_req_next.drive_count = s1_nxt_reg ? 2'd2 : 2'd1;
            s2_req_next.pcl         = maxcyl[7:0];
            s2_req_next.psc         = spt | {maxcyl[9:8], 6'b0};
            s2_req_next.pmh         = nhead - 8'd1;
        end else if (bad_geom) begin
            s2_req_next.carry = 1'b1;
        end else if (s1_cnt_reg == 8'd0) begin
            s2_req_next.carry = 1'b0;
        end else begin
            s2_req_next.is_status = 1'b0;
        end
    end

    // product fits in 27 bits: part < 2^18, spt < 2^8
    always_comb begin
        q_data     = s2_req_reg;
        q_data.lba = {5'b0, {8'b0, s2_part_reg} * {19'b0, s2_spt_reg}} +
                     {26'b0, s2_sec_reg - 6'd1};
    end

endmodule
`default_nettype wire

// ===== rtl/core/dctl_queue.sv =====
`default_nettype none
module dctl_queue (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           push,
    input  wire dctl_pkg::req_t push_data,
    output logic                full,
    input  wire logic           pop,
    output dctl_pkg::req_t      head,
    output logic                nonempty
);

    localparam int CNT_W = dctl_pkg::QPTR_W + 1;

    dctl_pkg::req_t                entry_reg [dctl_pkg::QUEUE_DEPTH];
    logic [dctl_pkg::QPTR_W-1:0]   wptr_reg, wptr_next, rptr_reg, rptr_next;
    logic [CNT_W-1:0]              cnt_reg, cnt_next;

    assign full     = (cnt_reg == CNT_W'(dctl_pkg::QUEUE_DEPTH));
    assign nonempty = (cnt_reg != '0);
    assign head     = entry_reg[rptr_reg];

    always_comb begin
        wptr_next = push ? wptr_reg + 1'b1 : wptr_reg;
        rptr_next = pop ? rptr_reg + 1'b1 : rptr_reg;
        cnt_next  = cnt_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wptr_reg] <= push_data;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/dctl_back.sv =====
`default_nettype none
module dctl_back (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire dctl_pkg::req_t q_head,
    input  wire logic           q_nonempty,
    output logic                q_pop,
    output logic                m_valid,
    input  wire logic           m_ready,
    output logic                m_kind,
    output logic [31:0]         m_sector_lba,
    output logic [19:0]         m_memory_address,
    output logic                m_is_write,
    output logic                m_last,
    output logic                m_carry,
    output logic [1:0]          m_drive_count,
    output logic [7:0]          m_param_cyl_low,
    output logic [7:0]          m_param_sector_cyl_high,
    output logic [7:0]          m_param_max_head
);

    // current transfer in progress
    logic        act_reg, act_next;
    logic [31:0] lba_reg, lba_next;
    logic [19:0] base_reg, base_next;
    logic [15:0] off_reg, off_next;
    logic [5:0]  left_reg, left_next;
    logic        wr_reg, wr_next;

    // output beat register
    logic        mv_reg, mv_next;
    logic        kind_reg, kind_next;
    logic [31:0] olba_reg, olba_next;
    logic [19:0] addr_reg, addr_next;
    logic        owr_reg, owr_next;
    logic        last_reg, last_next;
    logic        carry_reg, carry_next;
    logic [1:0]  dc_reg, dc_next;
    logic [7:0]  pcl_reg, pcl_next, psc_reg, psc_next, pmh_reg, pmh_next;

    logic        load;
    logic [31:0] src_lba;
    logic [19:0] src_base;
    logic [15:0] src_off;
    logic [5:0]  src_left;
    logic        src_wr;

    assign load  = !mv_reg || m_ready;
    assign q_pop = load && !act_reg && q_nonempty;

    always_comb begin
        src_lba  = act_reg ? lba_reg  : q_head.lba;
        src_base = act_reg ? base_reg : q_head.seg_base;
        src_off  = act_reg ? off_reg  : q_head.offset;
        src_left = act_reg ? left_reg : q_head.count;
        src_wr   = act_reg ? wr_reg   : q_head.is_write;

        act_next   = act_reg;
        lba_next   = lba_reg;
        base_next  = base_reg;
        off_next   = off_reg;
        left_next  = left_reg;
        wr_next    = wr_reg;
        mv_next    = mv_reg && !m_ready;
        kind_next  = kind_reg;
        olba_next  = olba_reg;
        addr_next  = addr_reg;
        owr_next   = owr_reg;
        last_next  = last_reg;
        carry_next = carry_reg;
        dc_next    = dc_reg;
        pcl_next   = pcl_reg;
        psc_next   = psc_reg;
        pmh_next   = pmh_reg;

        if (load && (act_reg || q_nonempty)) begin
            mv_next = 1'b1;
            if (!act_reg && q_head.is_status) begin
                kind_next  = 1'b1;
                olba_next  = '0;
                addr_next  = '0;
                owr_next   = 1'b0;
                last_next  = 1'b1;
                carry_next = q_head.carry;
                dc_next    = q_head.drive_count;
                pcl_next   = q_head.pcl;
                psc_next   = q_head.psc;
                pmh_next   = q_head.pmh;
            end else begin
                kind_next  = 1'b0;
                olba_next  = src_lba;
                addr_next  = src_base + {4'b0, src_off};
                owr_next   = src_wr;
                last_next  = (src_left == 6'd1);
                carry_next = 1'b0;
                dc_next    = '0;
                pcl_next   = '0;
                psc_next   = '0;
                pmh_next   = '0;
                act_next   = (src_left != 6'd1);
                lba_next   = src_lba + 32'd1;
                base_next  = src_base;
                off_next   = src_off + dctl_pkg::SECTOR_STEP;
                left_next  = src_left - 6'd1;
                wr_next    = src_wr;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            act_reg <= 1'b0;
            mv_reg  <= 1'b0;
        end else begin
            act_reg <= act_next;
            mv_reg  <= mv_next;
        end
    end

    always_ff @(posedge aclk) begin
        lba_reg   <= lba_next;
        base_reg  <= base_next;
        off_reg   <= off_next;
        left_reg  <= left_next;
        wr_reg    <= wr_next;
        kind_reg  <= kind_next;
        olba_reg  <= olba_next;
        addr_reg  <= addr_next;
        owr_reg   <= owr_next;
        last_reg  <= last_next;
        carry_reg <= carry_next;
        dc_reg    <= dc_next;
        pcl_reg   <= pcl_next;
        psc_reg   <= psc_next;
        pmh_reg   <= pmh_next;
    end

    assign m_valid                 = mv_reg;
    assign m_kind                  = kind_reg;
    assign m_sector_lba            = olba_reg;
    assign m_memory_address        = addr_reg;
    assign m_is_write              = owr_reg;
    assign m_last                  = last_reg;
    assign m_carry                 = carry_reg;
    assign m_drive_count           = dc_reg;
    assign m_param_cyl_low         = pcl_reg;
    assign m_param_sector_cyl_high = psc_reg;
    assign m_param_max_head        = pmh_reg;

    a_left_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        act_reg |-> left_reg != 6'd0)
        else $error("active transfer with no sectors left");

    a_status_last: assert property (@(posedge aclk) disable iff (!aresetn)
        mv_reg && kind_reg |-> last_reg)
        else $error("status beat without last");

    a_carry_status: assert property (@(posedge aclk) disable iff (!aresetn)
        mv_reg && carry_reg |-> kind_reg)
        else $error("carry on a transfer beat");

    a_lba_step: assert property (@(posedge aclk) disable iff (!aresetn)
        mv_reg && m_ready && !kind_reg && !last_reg |=>
            mv_reg && !kind_reg && olba_reg == $past(olba_reg) + 32'd1)
        else $error("transfer beats not consecutive");

endmodule
`default_nettype wire

// ===== dv/tb.sv =====
module tb;

    localparam int CYCLE_LIMIT     = 1_000_000;
    localparam int SETTLE_CYCLES   = 8;
    localparam int TAIL_CYCLES     = 16;
    localparam int LONG_HOLD       = 400;
    localparam int RANDOM_PHASES   = 9;
    localparam int ITEMS_PER_PHASE = 50;

    localparam logic [dctl_pkg::CFG_IDX_W-1:0] REG_DRIVE_SLOT_0 = 4'd0;
    localparam logic [dctl_pkg::CFG_IDX_W-1:0] REG_DRIVE_SLOT_1 = 4'd1;
    localparam logic [dctl_pkg::CFG_IDX_W-1:0] REG_DRIVE_SLOT_2 = 4'd2;
    localparam logic [dctl_pkg::CFG_IDX_W-1:0] REG_DRIVE_SLOT_3 = 4'd3;
    localparam logic [dctl_pkg::CFG_IDX_W-1:0] REG_UNMAPPED     = 4'd15;

    localparam logic KIND_SECTOR = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    typedef struct packed {
        dctl_pkg::action_t action;
        logic [7:0]        drive;
        logic [7:0]        cyl_low;
        logic [7:0]        sec_cyl_high;
        logic [7:0]        head;
        logic [7:0]        count;
        logic [15:0]       segment;
        logic [15:0]       offset;
    } disk_request_t;

    typedef struct packed {
        logic        kind;
        logic [31:0] lba;
        logic [19:0] addr;
        logic        is_write;
        logic        last;
        logic        carry;
        logic [1:0]  drive_count;
        logic [7:0]  cyl_low;
        logic [7:0]  sec_cyl_high;
        logic [7:0]  max_head;
    } disk_reply_t;

    typedef struct packed {
        logic                           is_cfg;
        logic [dctl_pkg::CFG_IDX_W-1:0] reg_index;
        logic [dctl_pkg::SLOT_W-1:0]    reg_value;
        disk_request_t                  req;
        logic                           typed;
        disk_reply_t                    reply;
    } stim_row_t;

    logic                           aclk      = 1'b0;
    logic                           aresetn   = 1'b0;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [dctl_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [dctl_pkg::SLOT_W-1:0]    cfg_data  = '0;
    logic                           s_valid   = 1'b0;
    logic                           s_ready;
    logic [1:0]                     s_action  = '0;
    logic [7:0]                     s_drive_number        = '0;
    logic [7:0]                     s_cyl_low             = '0;
    logic [7:0]                     s_sector_and_cyl_high = '0;
    logic [7:0]                     s_head_number         = '0;
    logic [7:0]                     s_sector_count        = '0;
    logic [15:0]                    s_buffer_segment      = '0;
    logic [15:0]                    s_buffer_offset       = '0;
    logic                           m_valid;
    logic                           m_ready   = 1'b0;
    logic                           m_kind;
    logic [31:0]                    m_sector_lba;
    logic [19:0]                    m_memory_address;
    logic                           m_is_write;
    logic                           m_last;
    logic                           m_carry;
    logic [1:0]                     m_drive_count;
    logic [7:0]                     m_param_cyl_low;
    logic [7:0]                     m_param_sector_cyl_high;
    logic [7:0]                     m_param_max_head;

    logic [dctl_pkg::SLOT_W-1:0] slot_shadow [dctl_pkg::DRIVE_SLOTS];
    disk_reply_t                 expected_replies [$];
    int                          failures     = 0;
    logic                        tx_idle_on   = 1'b1;
    logic                        rx_idle_on   = 1'b1;
    logic                        hold_request = 1'b0;

    disk_chs_to_lba_service i_dut (.*);

    always #6 aclk = ~aclk;

    function automatic logic [dctl_pkg::SLOT_W-1:0] pack_slot(logic [7:0] drv,
                                                              logic [15:0] cyls,
                                                              logic [7:0] heads,
                                                              logic [7:0] spt);
        return {spt, heads, cyls, drv, 1'b1};
    endfunction

    function automatic int lookup_slot(logic [7:0] drv);
        for (int i = 0; i < dctl_pkg::DRIVE_SLOTS; i++) begin
            if (slot_shadow[i][0] && slot_shadow[i][8:1] == drv)
                return i;
        end
        return -1;
    endfunction

    function automatic disk_reply_t status_reply(logic carry);
        disk_reply_t rp;
        rp       = '0;
        rp.kind  = KIND_STATUS;
        rp.last  = 1'b1;
        rp.carry = carry;
        return rp;
    endfunction

    function automatic disk_request_t make_request(dctl_pkg::action_t act, logic [7:0] drv,
                                                   logic [9:0] cyl, logic [5:0] sec,
                                                   logic [7:0] head, logic [7:0] cnt,
                                                   logic [15:0] seg, logic [15:0] off);
        disk_request_t r;
        r.action       = act;
        r.drive        = drv;
        r.cyl_low      = cyl[7:0];
        r.sec_cyl_high = {cyl[9:8], sec};
        r.head         = head;
        r.count        = cnt;
        r.segment      = seg;
        r.offset       = off;
        return r;
    endfunction

    // Queues the results one request produces against the current slot settings.
    function automatic void serve_request(disk_request_t r);
        disk_reply_t                 rp;
        logic [dctl_pkg::SLOT_W-1:0] v;
        logic [15:0]                 ncyl;
        logic [15:0]                 max_cyl;
        logic [15:0]                 off;
        logic [7:0]                  nhead;
        logic [7:0]                  spt;
        logic [9:0]                  cyl;
        logic [5:0]                  sec;
        logic [31:0]                 lba;
        int                          slot;
        cyl = {r.sec_cyl_high[7:6], r.cyl_low};
        sec = r.sec_cyl_high[5:0];
        if (r.action == dctl_pkg::ACT_RESET) begin
            expected_replies.push_back(status_reply(1'b0));
            return;
        end
        slot = lookup_slot(r.drive);
        if (slot < 0) begin
            expected_replies.push_back(status_reply(1'b1));
            return;
        end
        v     = slot_shadow[slot];
        ncyl  = v[24:9];
        nhead = v[32:25];
        spt   = v[40:33];
        if (r.action == dctl_pkg::ACT_PARAMS) begin
            max_cyl         = ncyl - 16'd1;
            rp              = status_reply(1'b0);
            rp.drive_count  = (lookup_slot(r.drive + 8'd1) >= 0) ? 2'd2 : 2'd1;
            rp.cyl_low      = max_cyl[7:0];
            rp.sec_cyl_high = spt | {max_cyl[9:8], 6'd0};
            rp.max_head     = nhead - 8'd1;
            expected_replies.push_back(rp);
            return;
        end
        if (16'(cyl) >= ncyl || r.head >= nhead || sec == 6'd0 || 8'(sec) > spt ||
            int'(sec) + int'(r.count) > int'(spt) + 1 ||
            int'(r.count) > dctl_pkg::MAX_XFER) begin
            expected_replies.push_back(status_reply(1'b1));
            return;
        end
        if (r.count == 8'd0) begin
            expected_replies.push_back(status_reply(1'b0));
            return;
        end
        lba = 32'(sec) - 32'd1 + 32'(spt) * (32'(r.head) + 32'(cyl) * 32'(nhead));
        off = r.offset;
        for (int k = 0; k < int'(r.count); k++) begin
            rp          = '0;
            rp.kind     = KIND_SECTOR;
            rp.lba      = lba;
            rp.addr     = {r.segment, 4'd0} + {4'd0, off};
            rp.is_write = (r.action == dctl_pkg::ACT_WRITE);
            rp.last     = (k == int'(r.count) - 1);
            expected_replies.push_back(rp);
            lba = lba + 32'd1;
            off = off + 16'(dctl_pkg::SECTOR_BYTES);
        end
    endfunction

    function automatic stim_row_t cfg_row(logic [dctl_pkg::CFG_IDX_W-1:0] idx,
                                          logic [dctl_pkg::SLOT_W-1:0] value);
        stim_row_t row;
        row           = '0;
        row.is_cfg    = 1'b1;
        row.reg_index = idx;
        row.reg_value = value;
        return row;
    endfunction

    function automatic stim_row_t xfer_row(dctl_pkg::action_t act, logic [7:0] drv,
                                           logic [9:0] cyl, logic [5:0] sec,
                                           logic [7:0] head, logic [7:0] cnt,
                                           logic [15:0] seg, logic [15:0] off);
        stim_row_t row;
        row     = '0;
        row.req = make_request(act, drv, cyl, sec, head, cnt, seg, off);
        return row;
    endfunction

    function automatic stim_row_t status_row(dctl_pkg::action_t act, logic [7:0] drv,
                                             logic [9:0] cyl, logic [5:0] sec,
                                             logic [7:0] head, logic [7:0] cnt,
                                             logic carry);
        stim_row_t row;
        row       = '0;
        row.req   = make_request(act, drv, cyl, sec, head, cnt, 16'($urandom), 16'($urandom));
        row.typed = 1'b1;
        row.reply = status_reply(carry);
        return row;
    endfunction

    function automatic stim_row_t params_row(logic [7:0] drv, logic [1:0] dc, logic [7:0] pcl,
                                             logic [7:0] psc, logic [7:0] pmh);
        stim_row_t row;
        row       = '0;
        row.req   = make_request(dctl_pkg::ACT_PARAMS, drv, 10'($urandom), 6'($urandom),
                                 8'($urandom), 8'($urandom), 16'($urandom), 16'($urandom));
        row.typed = 1'b1;
        row.reply = status_reply(1'b0);
        row.reply.drive_count  = dc;
        row.reply.cyl_low      = pcl;
        row.reply.sec_cyl_high = psc;
        row.reply.max_head     = pmh;
        return row;
    endfunction

    function automatic logic [dctl_pkg::SLOT_W-1:0] random_slot();
        logic [7:0]  drv;
        logic [7:0]  heads;
        logic [7:0]  spt;
        logic [15:0] cyls;
        int          pick;
        pick = $urandom_range(0, 99);
        if (pick < 8)
            return dctl_pkg::SLOT_W'({$urandom(), $urandom()});
        if (pick < 16)
            return {40'({$urandom(), $urandom()}), 1'b0};
        case ($urandom_range(0, 5))
            0: drv = 8'h00;
            1: drv = 8'h01;
            2: drv = 8'h80;
            3: drv = 8'h81;
            4: drv = 8'hFF;
            default: drv = 8'($urandom);
        endcase
        case ($urandom_range(0, 2))
            0: cyls = 16'($urandom_range(1, 4));
            1: cyls = 16'($urandom_range(1, 1024));
            default: cyls = 16'($urandom_range(1, 65535));
        endcase
        heads = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(1, 16))
                                            : 8'($urandom_range(1, 255));
        pick = $urandom_range(0, 99);
        if (pick < 80)      spt = 8'($urandom_range(1, 63));
        else if (pick < 95) spt = 8'($urandom_range(64, 255));
        else                spt = 8'd0;
        return pack_slot(drv, cyls, heads, spt);
    endfunction

    // Mostly well-formed transfers on a configured drive, some with one field pushed
    // just past its limit, plus a share of fully random requests.
    function automatic disk_request_t random_request();
        logic [dctl_pkg::SLOT_W-1:0] v;
        logic [7:0]                  drv;
        dctl_pkg::action_t           act;
        int ncyl, nhead, spt, cyl, head, sec, cnt, room, pick;
        v     = slot_shadow[$urandom_range(0, dctl_pkg::DRIVE_SLOTS - 1)];
        drv   = v[8:1];
        ncyl  = int'(v[24:9]);
        nhead = int'(v[32:25]);
        spt   = int'(v[40:33]);
        pick  = $urandom_range(0, 99);
        if (pick < 15 || ncyl == 0 || nhead == 0 || spt == 0)
            return make_request(dctl_pkg::action_t'(2'($urandom)),
                                (pick < 8) ? 8'($urandom) : drv,
                                10'($urandom), 6'($urandom), 8'($urandom), 8'($urandom),
                                16'($urandom), 16'($urandom));
        pick = $urandom_range(0, 99);
        if (pick < 5)       act = dctl_pkg::ACT_RESET;
        else if (pick < 45) act = dctl_pkg::ACT_READ;
        else if (pick < 85) act = dctl_pkg::ACT_WRITE;
        else                act = dctl_pkg::ACT_PARAMS;
        if (act == dctl_pkg::ACT_RESET || act == dctl_pkg::ACT_PARAMS)
            return make_request(act, drv, 10'($urandom), 6'($urandom), 8'($urandom),
                                8'($urandom), 16'($urandom), 16'($urandom));
        cyl  = $urandom_range(0, ((ncyl > 1024) ? 1024 : ncyl) - 1);
        head = $urandom_range(0, nhead - 1);
        sec  = $urandom_range(1, (spt > 63) ? 63 : spt);
        room = spt + 1 - sec;
        if (room > dctl_pkg::MAX_XFER)
            room = dctl_pkg::MAX_XFER;
        pick = $urandom_range(0, 99);
        if (pick < 65)      cnt = $urandom_range(0, (room > 8) ? 8 : room);
        else if (pick < 90) cnt = $urandom_range(0, room);
        else                cnt = $urandom_range(0, 255);
        if ($urandom_range(0, 9) == 0) begin
            case ($urandom_range(0, 3))
                0: sec = 0;
                1: head = nhead;
                2: begin
                    if (ncyl < 1024)   cyl = ncyl;
                    else if (spt < 63) sec = spt + 1;
                    else               sec = 0;
                end
                default: cnt = room + 1;
            endcase
        end
        return make_request(act, drv, 10'(cyl), 6'(sec), 8'(head), 8'(cnt),
                            16'($urandom), 16'($urandom));
    endfunction

    task automatic send_request(input disk_request_t r, input logic typed,
                                input disk_reply_t typed_reply);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, 7) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid               <= 1'b1;
        s_action              <= r.action;
        s_drive_number        <= r.drive;
        s_cyl_low             <= r.cyl_low;
        s_sector_and_cyl_high <= r.sec_cyl_high;
        s_head_number         <= r.head;
        s_sector_count        <= r.count;
        s_buffer_segment      <= r.segment;
        s_buffer_offset       <= r.offset;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (typed)
            expected_replies.push_back(typed_reply);
        else
            serve_request(r);
        @(negedge aclk);
    endtask

    // Drops the request line and waits for the block to drain before a register write.
    task automatic settle();
        s_valid <= 1'b0;
        while (expected_replies.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic cfg_write(input logic [dctl_pkg::CFG_IDX_W-1:0] idx,
                             input logic [dctl_pkg::SLOT_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        if (idx < dctl_pkg::DRIVE_SLOTS)
            slot_shadow[idx] = value;
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
            failures++;
        end
    endtask

    always @(posedge aclk) begin : reply_checker
        disk_reply_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_replies.size() == 0) begin
                $display("%0t: result beat with nothing expected, kind %0b lba %0h last %0b",
                         $time, m_kind, m_sector_lba, m_last);
                failures++;
            end else begin
                want = expected_replies.pop_front();
                check_field("kind", 32'(want.kind), 32'(m_kind));
                check_field("sector_lba", want.lba, m_sector_lba);
                check_field("memory_address", 32'(want.addr), 32'(m_memory_address));
                check_field("is_write", 32'(want.is_write), 32'(m_is_write));
                check_field("last", 32'(want.last), 32'(m_last));
                check_field("carry", 32'(want.carry), 32'(m_carry));
                check_field("drive_count", 32'(want.drive_count), 32'(m_drive_count));
                check_field("param_cyl_low", 32'(want.cyl_low), 32'(m_param_cyl_low));
                check_field("param_sector_cyl_high", 32'(want.sec_cyl_high),
                            32'(m_param_sector_cyl_high));
                check_field("param_max_head", 32'(want.max_head), 32'(m_param_max_head));
            end
        end
    end

    initial begin : result_sink
        int stall;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            if (hold_request) begin
                stall        = LONG_HOLD;
                hold_request = 1'b0;
            end else begin
                stall = rx_idle_on ? $urandom_range(0, 7) : 0;
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            @(negedge aclk);
        end
    end

    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("Test completed with failures");
        $finish;
    end

    initial begin : stimulus
        stim_row_t rows [$];
        int        phase;
        for (int i = 0; i < dctl_pkg::DRIVE_SLOTS; i++)
            slot_shadow[i] = '0;
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // all slots absent after reset
        rows.push_back(status_row(dctl_pkg::ACT_RESET, 8'h80, 10'd0, 6'd1, 8'd0, 8'd1, 1'b0));
        rows.push_back(status_row(dctl_pkg::ACT_READ, 8'h00, 10'd0, 6'd1, 8'd0, 8'd1, 1'b1));
        rows.push_back(status_row(dctl_pkg::ACT_PARAMS, 8'h80, 10'd0, 6'd1, 8'd0, 8'd1,
                                  1'b1));
        rows.push_back(cfg_row(REG_DRIVE_SLOT_0, pack_slot(8'h80, 16'd1024, 8'd16, 8'd63)));
        rows.push_back(cfg_row(REG_DRIVE_SLOT_1, pack_slot(8'h81, 16'd1, 8'd1, 8'd1)));
        rows.push_back(cfg_row(REG_DRIVE_SLOT_2, pack_slot(8'h00, 16'd80, 8'd2, 8'd18)));
        rows.push_back(cfg_row(REG_DRIVE_SLOT_3, {dctl_pkg::SLOT_W{1'b1}}));
        rows.push_back(cfg_row(REG_UNMAPPED, '0));
        rows.push_back(params_row(8'h80, 2'd2, 8'hFF, 8'hFF, 8'h0F));
        rows.push_back(params_row(8'h81, 2'd1, 8'h00, 8'h01, 8'h00));
        // next drive number wraps to 0x00
        rows.push_back(params_row(8'hFF, 2'd2, 8'hFE, 8'hFF, 8'hFE));
        rows.push_back(params_row(8'h00, 2'd1, 8'h4F, 8'h12, 8'h01));
        rows.push_back(xfer_row(dctl_pkg::ACT_READ, 8'h80, 10'd0, 6'd1, 8'd0, 8'd1,
                                16'h0, 16'h0));
        rows.push_back(xfer_row(dctl_pkg::ACT_WRITE, 8'h80, 10'd1023, 6'd63, 8'd15, 8'd1,
                                16'hFFFF, 16'hFFFF));
        // offset wraps inside the segment partway through
        rows.push_back(xfer_row(dctl_pkg::ACT_READ, 8'h80, 10'd5, 6'd1, 8'd3, 8'd63,
                                16'h1234, 16'hFE00));
        rows.push_back(status_row(dctl_pkg::ACT_READ, 8'h80, 10'd0, 6'd0, 8'd0, 8'd1, 1'b1));
        rows.push_back(status_row(dctl_pkg::ACT_READ, 8'h00, 10'd80, 6'd1, 8'd0, 8'd1, 1'b1));
        rows.push_back(status_row(dctl_pkg::ACT_READ, 8'h80, 10'd0, 6'd1, 8'd16, 8'd1, 1'b1));
        rows.push_back(status_row(dctl_pkg::ACT_READ, 8'h00, 10'd0, 6'd19, 8'd0, 8'd1, 1'b1));
        rows.push_back(status_row(dctl_pkg::ACT_READ, 8'h00, 10'd0, 6'd10, 8'd1, 8'd10,
                                  1'b1));
        rows.push_back(xfer_row(dctl_pkg::ACT_WRITE, 8'h00, 10'd79, 6'd10, 8'd1, 8'd9,
                                16'hF000, 16'h8000));
        rows.push_back(status_row(dctl_pkg::ACT_READ, 8'h80, 10'd0, 6'd1, 8'd0, 8'd0, 1'b0));
        rows.push_back(status_row(dctl_pkg::ACT_READ, 8'hFF, 10'd0, 6'd1, 8'd0, 8'd64, 1'b1));
        rows.push_back(status_row(dctl_pkg::ACT_WRITE, 8'hFF, 10'd0, 6'd1, 8'd0, 8'd255,
                                  1'b1));
        rows.push_back(xfer_row(dctl_pkg::ACT_WRITE, 8'hFF, 10'd1023, 6'd63, 8'd254, 8'd63,
                                16'hFFFF, 16'h0001));
        rows.push_back(status_row(dctl_pkg::ACT_RESET, 8'hFF, 10'd1023, 6'd63, 8'd255,
                                  8'd255, 1'b0));
        rows.push_back(xfer_row(dctl_pkg::ACT_READ, 8'h81, 10'd0, 6'd1, 8'd0, 8'd1,
                                16'hABCD, 16'h0));
        // duplicate drive number (first slot wins) and an all-zero geometry
        rows.push_back(cfg_row(REG_DRIVE_SLOT_1, pack_slot(8'h80, 16'd2, 8'd2, 8'd2)));
        rows.push_back(cfg_row(REG_DRIVE_SLOT_2, pack_slot(8'h10, 16'd0, 8'd0, 8'd0)));
        rows.push_back(params_row(8'h10, 2'd1, 8'hFF, 8'hC0, 8'hFF));
        rows.push_back(xfer_row(dctl_pkg::ACT_READ, 8'h80, 10'd1000, 6'd63, 8'd15, 8'd1,
                                16'h0040, 16'h0100));
        rows.push_back(status_row(dctl_pkg::ACT_READ, 8'h10, 10'd0, 6'd1, 8'd0, 8'd1, 1'b1));

        foreach (rows[k]) begin
            if (rows[k].is_cfg) begin
                settle();
                cfg_write(rows[k].reg_index, rows[k].reg_value);
            end else begin
                send_request(rows[k].req, rows[k].typed, rows[k].reply);
            end
        end

        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            settle();
            if (phase == 0) begin
                cfg_write(REG_DRIVE_SLOT_0, {dctl_pkg::SLOT_W{1'b1}});
                cfg_write(REG_DRIVE_SLOT_1, {dctl_pkg::SLOT_W{1'b1}});
                cfg_write(REG_DRIVE_SLOT_2, {dctl_pkg::SLOT_W{1'b1}});
                cfg_write(REG_DRIVE_SLOT_3, {dctl_pkg::SLOT_W{1'b1}});
            end else begin
                cfg_write(REG_DRIVE_SLOT_0, random_slot());
                cfg_write(REG_DRIVE_SLOT_1, random_slot());
                cfg_write(REG_DRIVE_SLOT_2, random_slot());
                cfg_write(REG_DRIVE_SLOT_3, random_slot());
            end
            tx_idle_on = (phase % 4 == 0) || (phase % 4 == 3);
            rx_idle_on = (phase % 4 == 0) || (phase % 4 == 2);
            // back-to-back requests against a stalled sink fill the queue
            if (phase == 2)
                hold_request = 1'b1;
            repeat (ITEMS_PER_PHASE) send_request(random_request(), 1'b0, '0);
        end

        rx_idle_on = 1'b0;
        settle();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
